FILE: rtl/core/sacrs_pkg.sv
// Shared types and constants for the SPI converter channel read sequencer.
package sacrs_pkg;

  localparam int unsigned ChanW     = 3;
  localparam int unsigned WordW     = 16;
  localparam int unsigned ChanShift = 11;

  // One half-bit tick presented to the sequencer.
  typedef struct packed {
    logic             miso;
    logic [ChanW-1:0] next_channel;
    logic [ChanW-1:0] this_channel;
    logic             start_req;
  } tick_t;

  // Pin levels and status produced for one tick.
  typedef struct packed {
    logic [WordW-1:0] sample;
    logic             done_res;
    logic             busy_res;
    logic             mosi;
    logic             sclk;
    logic             cs_n;
  } pins_t;

  // Control word: channel in bits 13..11, everything else zero.
  function automatic logic [WordW-1:0] ctrl_word(input logic [ChanW-1:0] ch);
    ctrl_word = WordW'(ch) << ChanShift;
  endfunction

endpackage

FILE: rtl/core/sacrs_engine.sv
// Frame sequencer state and the per-tick pin logic.
module sacrs_engine
  import sacrs_pkg::*;
#(
  parameter int unsigned FRAME_BITS = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  step_i,
  input  tick_t tick_i,
  output pins_t pins_o
);

  localparam int unsigned CntW = $clog2(FRAME_BITS + 1);

  typedef enum logic [2:0] {
    StIdle    = 3'd0,
    StSelect  = 3'd1,
    StClkLow  = 3'd2,
    StClkHigh = 3'd3,
    StRelease = 3'd4
  } state_e;

  state_e           state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d, cnt_inc;
  logic [WordW-1:0] shift_q, shift_d;
  logic [ChanW-1:0] mux_ch_q, mux_ch_d;
  logic             mux_known_q, mux_known_d;
  logic             pending_q, pending_d;
  logic [ChanW-1:0] held_ch_q, held_ch_d;
  pins_t            pins;

  assign cnt_inc = cnt_q + CntW'(1);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    shift_d     = shift_q;
    mux_ch_d    = mux_ch_q;
    mux_known_d = mux_known_q;
    pending_d   = pending_q;
    held_ch_d   = held_ch_q;
    pins        = '{sample: '0, done_res: 1'b0, busy_res: 1'b0, mosi: 1'b0,
                    sclk: 1'b1, cs_n: 1'b1};
    case (state_q)
      StSelect: begin
        pins.cs_n     = 1'b0;
        pins.busy_res = 1'b1;
        state_d       = StClkLow;
      end
      StClkLow: begin
        pins.cs_n     = 1'b0;
        pins.sclk     = 1'b0;
        pins.mosi     = shift_q[WordW-1];
        pins.busy_res = 1'b1;
        state_d       = StClkHigh;
      end
      StClkHigh: begin
        pins.cs_n     = 1'b0;
        pins.mosi     = shift_q[WordW-1];
        pins.busy_res = 1'b1;
        shift_d       = {shift_q[WordW-2:0], tick_i.miso};
        cnt_d         = cnt_inc;
        state_d       = (cnt_inc >= CntW'(FRAME_BITS)) ? StRelease : StClkLow;
      end
      StRelease: begin
        pins.busy_res = 1'b1;
        if (pending_q) begin
          pending_d = 1'b0;
          shift_d   = ctrl_word(held_ch_q);
          cnt_d     = '0;
          state_d   = StSelect;
        end else begin
          pins.done_res = 1'b1;
          pins.sample   = shift_q;
          state_d       = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
        if (tick_i.start_req) begin
          pins.cs_n     = 1'b0;
          pins.busy_res = 1'b1;
          // Run a dummy frame first when the mux is not on the wanted channel.
          if (!mux_known_q || tick_i.this_channel != mux_ch_q) begin
            shift_d   = ctrl_word(tick_i.this_channel);
            pending_d = 1'b1;
          end else begin
            shift_d   = ctrl_word(tick_i.next_channel);
            pending_d = 1'b0;
          end
          cnt_d       = '0;
          held_ch_d   = tick_i.next_channel;
          mux_ch_d    = tick_i.next_channel;
          mux_known_d = 1'b1;
          state_d     = StClkLow;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      shift_q     <= '0;
      mux_ch_q    <= '0;
      mux_known_q <= 1'b0;
      pending_q   <= 1'b0;
      held_ch_q   <= '0;
    end else if (step_i) begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      shift_q     <= shift_d;
      mux_ch_q    <= mux_ch_d;
      mux_known_q <= mux_known_d;
      pending_q   <= pending_d;
      held_ch_q   <= held_ch_d;
    end
  end

  assign pins_o = pins;

endmodule

FILE: rtl/core/spi_adc_channel_read_sequencer_top.sv
// Top level of the SPI converter channel read sequencer.
//
// Each input transaction is one half-bit tick of a bit-banged SPI master for an
// 8-channel serial converter; each tick yields exactly one output transaction
// carrying the pin levels (cs_n, sclk, mosi) and status (busy, done, sample).
// A read asserts chip select, clocks a 16-bit control word out MSB first with
// the channel in bits 13..11 (clock low with data, then high, data-in sampled
// on the high tick), and releases chip select; when the converter mux is not
// already on the wanted channel a dummy frame runs first. One frame spans
// 2*FRAME_BITS+2 ticks. Throughput is one transaction per clock cycle when the
// master side does not stall: the tick is evaluated by the sequencer logic in
// the cycle it is accepted and lands in the output register. The slave side
// stays ready while the output register is empty or being drained in the same
// cycle; a stalled master side holds its transaction and backpressures the input.
module spi_adc_channel_read_sequencer_top
  import sacrs_pkg::*;
#(
  parameter int unsigned FRAME_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [0] start_req, [3:1] this_channel, [6:4] next_channel, [7] miso
  input  logic [7:0]  s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] cs_n, [1] sclk, [2] mosi, [3] busy_res, [4] done_res,
  // [20:5] sample, [23:21] zero
  output logic [23:0] m_axis_tdata_o
);

  logic  in_fire;
  tick_t tick;
  pins_t pins;
  logic  out_valid_q;
  pins_t out_q;

  // Accept a new tick whenever the output slot is free or draining now.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign tick = tick_t'(s_axis_tdata_i);

  sacrs_engine #(
    .FRAME_BITS(FRAME_BITS)
  ) u_engine (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(in_fire),
    .tick_i(tick),
    .pins_o(pins)
  );

  // Output valid flag: set on accept, drop once the transaction is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload: hold while stalled, advance on every accepted tick.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= pins;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_q};

endmodule

FILE: rtl/core/sacrs_checker.sv
// Port-level assertions for the sequencer top level, attached by bind.
module sacrs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o
);

  // Done only ever closes a busy sequence.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[4] |-> m_axis_tdata_o[3])
    else $error("done without busy");

  // Sample is zero except on the done tick.
  a_sample_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[4] |-> m_axis_tdata_o[20:5] == 16'd0)
    else $error("sample nonzero outside done");

  // Idle pins: chip select released, clock high, data low.
  a_idle_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[3] |->
      m_axis_tdata_o[0] && m_axis_tdata_o[1] && !m_axis_tdata_o[2])
    else $error("pins active while idle");

  // Clock only toggles low inside a selected frame.
  a_sclk_cs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[1] |-> !m_axis_tdata_o[0])
    else $error("sclk low without chip select");

  // A stalled output transaction holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output transaction changed while stalled");

endmodule

bind spi_adc_channel_read_sequencer_top sacrs_checker u_sacrs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);

FILE: dv/spi_adc_channel_read_sequencer_top_tb.sv
// Self-checking stream testbench for the SPI converter channel read sequencer.
`timescale 1ns / 100ps

module spi_adc_channel_read_sequencer_top_tb;
  import sacrs_pkg::*;

  localparam int unsigned FrameBits  = 16;
  localparam int unsigned NumTicks   = 1150;
  localparam int unsigned CalmLo     = 500;   // accepted-tick window with no idling
  localparam int unsigned CalmHi     = 800;
  localparam int unsigned DrainAt    = 950;   // sender waits here for every result
  localparam int unsigned HoldStart  = 200;   // receiver hold-off, in cycles
  localparam int unsigned HoldLen    = 60;
  localparam int unsigned StallLimit = 1000;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SELECT,
    PH_CLK_LOW,
    PH_CLK_HIGH,
    PH_RELEASE
  } phase_e;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        in_valid = 1'b0;
  tick_t       in_data  = '0;
  logic        out_ready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [23:0] m_axis_tdata_o;

  spi_adc_channel_read_sequencer_top #(
    .FRAME_BITS(FrameBits)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(in_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (in_data),      // [0] start_req, [3:1] this_channel,
                                    // [6:4] next_channel, [7] miso
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(out_ready),
    .m_axis_tdata_o (m_axis_tdata_o) // [0] cs_n, [1] sclk, [2] mosi, [3] busy_res,
                                     // [4] done_res, [20:5] sample, [23:21] zero
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Sequencer state as predicted from the accepted ticks.
  phase_e      ph;
  logic [4:0]  bits_done;
  logic [15:0] shreg;
  logic [2:0]  mux_ch;
  logic        mux_valid;
  logic        second_pending;
  logic [2:0]  latched_next;

  int unsigned dummy_frames;
  int unsigned ignored_starts;
  int unsigned reads_done;

  pins_t       expected_pins[$];
  tick_t       tick_plan[$];
  int unsigned ticks_sent;
  int unsigned next_idx;
  int unsigned cyc;
  int unsigned stall_cyc;
  int unsigned err_cnt;
  int unsigned checked;
  pins_t       mon_got;
  pins_t       mon_want;

  // Advance the predicted sequencer by one tick and return its pin levels.
  function automatic pins_t step_sequencer(input tick_t t);
    pins_t p;
    logic  dbit;
    logic  was_busy;
    p        = '0;
    p.cs_n   = 1'b1;
    p.sclk   = 1'b1;
    dbit     = shreg[15];
    was_busy = (ph != PH_IDLE);
    case (ph)
      PH_SELECT: begin
        p.cs_n     = 1'b0;
        p.busy_res = 1'b1;
        ph         = PH_CLK_LOW;
      end
      PH_CLK_LOW: begin
        p.cs_n     = 1'b0;
        p.sclk     = 1'b0;
        p.mosi     = dbit;
        p.busy_res = 1'b1;
        ph         = PH_CLK_HIGH;
      end
      PH_CLK_HIGH: begin
        // sample data-in on the high half, shifting it in at bit 0
        p.cs_n     = 1'b0;
        p.mosi     = dbit;
        p.busy_res = 1'b1;
        shreg      = {shreg[14:0], t.miso};
        bits_done  = bits_done + 5'd1;
        ph         = (bits_done >= FrameBits) ? PH_RELEASE : PH_CLK_LOW;
      end
      PH_RELEASE: begin
        p.busy_res = 1'b1;
        if (second_pending) begin
          // dummy frame done: load the real one with the held channel
          second_pending = 1'b0;
          shreg          = {2'b00, latched_next, 11'b0};
          bits_done      = '0;
          ph             = PH_SELECT;
        end else begin
          p.done_res = 1'b1;
          p.sample   = shreg;
          ph         = PH_IDLE;
          reads_done++;
        end
      end
      default: begin
        ph = PH_IDLE;
        if (t.start_req) begin
          p.cs_n     = 1'b0;
          p.busy_res = 1'b1;
          if (!mux_valid || t.this_channel != mux_ch) begin
            shreg          = {2'b00, t.this_channel, 11'b0};
            second_pending = 1'b1;
            dummy_frames++;
          end else begin
            shreg          = {2'b00, t.next_channel, 11'b0};
            second_pending = 1'b0;
          end
          bits_done    = '0;
          latched_next = t.next_channel;
          mux_ch       = t.next_channel;
          mux_valid    = 1'b1;
          ph           = PH_CLK_LOW;
        end
      end
    endcase
    // a start that arrives while a sequence is running is dropped
    if (was_busy && t.start_req) begin
      ignored_starts++;
    end
    return p;
  endfunction

  // Stimulus planning: track where the mux should sit after each planned read.
  logic [2:0] plan_mux;
  bit         plan_known;

  function automatic tick_t rand_tick(input bit start);
    tick_t t;
    t.start_req    = start;
    t.this_channel = 3'($urandom_range(0, 7));
    t.next_channel = 3'($urandom_range(0, 7));
    t.miso         = 1'($urandom_range(0, 1));
    return t;
  endfunction

  // Queue one complete read: the start tick, every tick up to the ending tick
  // (starts in there must be ignored), and a short idle gap.
  task automatic plan_read(input logic [2:0] this_ch, input logic [2:0] next_ch,
                           input bit tail_start);
    tick_t       t;
    int unsigned body;
    body = (!plan_known || this_ch != plan_mux) ? 67 : 33;
    t = rand_tick(1'b1);
    t.this_channel = this_ch;
    t.next_channel = next_ch;
    tick_plan.push_back(t);
    for (int unsigned i = 1; i <= body; i++) begin
      tick_plan.push_back(rand_tick(i == body ? tail_start : ($urandom_range(0, 3) == 0)));
    end
    for (int unsigned i = $urandom_range(0, 3); i > 0; i--) begin
      tick_plan.push_back(rand_tick(1'b0));
    end
    plan_mux   = next_ch;
    plan_known = 1'b1;
  endtask

  // Sender: offer planned ticks, predict each accepted one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      next_idx = ticks_sent;
      if (in_valid && s_axis_tready_o) begin
        expected_pins.push_back(step_sequencer(in_data));
        next_idx = ticks_sent + 1;
      end
      if (!in_valid || s_axis_tready_o) begin
        if (next_idx < tick_plan.size() &&
            !(next_idx == DrainAt && expected_pins.size() != 0) &&
            ((next_idx >= CalmLo && next_idx < CalmHi) || $urandom_range(0, 99) >= 8)) begin
          in_valid <= 1'b1;
          in_data  <= tick_plan[next_idx];
        end else begin
          in_valid <= 1'b0;
        end
      end
      ticks_sent <= next_idx;
    end
  end

  // Receiver: random stalls, one long hold-off so the input backs up.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      cyc       <= 0;
    end else begin
      cyc <= cyc + 1;
      if (cyc >= HoldStart && cyc < HoldStart + HoldLen) begin
        out_ready <= 1'b0;
      end else if (ticks_sent >= CalmLo && ticks_sent < CalmHi) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 8);
      end
    end
  end

  // Checker: compare each output transaction with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && out_ready) begin
      mon_got = pins_t'(m_axis_tdata_o[20:0]);
      checked++;
      if (expected_pins.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) begin
          $display("%0t: unexpected output transaction %h", $realtime, m_axis_tdata_o);
        end
      end else begin
        mon_want = expected_pins.pop_front();
        if (mon_got !== mon_want || m_axis_tdata_o[23:21] !== 3'b000) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("%0t: tick %0d mismatch", $realtime, checked);
            $display("  expected cs_n=%b sclk=%b mosi=%b busy=%b done=%b sample=%h",
                     mon_want.cs_n, mon_want.sclk, mon_want.mosi, mon_want.busy_res,
                     mon_want.done_res, mon_want.sample);
            $display("  actual   cs_n=%b sclk=%b mosi=%b busy=%b done=%b sample=%h pad=%b",
                     mon_got.cs_n, mon_got.sclk, mon_got.mosi, mon_got.busy_res,
                     mon_got.done_res, mon_got.sample, m_axis_tdata_o[23:21]);
          end
        end
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && s_axis_tready_o) || (m_axis_tvalid_o && out_ready)) begin
        stall_cyc <= 0;
      end else if (stall_cyc >= StallLimit) begin
        $display("timeout after %0d idle cycles", stall_cyc);
        $display("[spi_adc_channel_read_sequencer_top] ERROR");
        $finish;
      end else begin
        stall_cyc <= stall_cyc + 1;
      end
    end
  end

  initial begin
    tick_t      t;
    logic [2:0] this_ch;
    logic [2:0] next_ch;

    ph             = PH_IDLE;
    bits_done      = '0;
    shreg          = '0;
    mux_ch         = '0;
    mux_valid      = 1'b0;
    second_pending = 1'b0;
    latched_next   = '0;
    dummy_frames   = 0;
    ignored_starts = 0;
    reads_done     = 0;
    ticks_sent     = 0;
    stall_cyc      = 0;
    err_cnt        = 0;
    checked        = 0;
    plan_known     = 1'b0;
    plan_mux       = '0;

    // Directed: idle ticks at the field extremes, then reads covering an
    // unknown mux that happens to match the reset value, a matching channel,
    // a channel change with a dummy frame, and a start on the ending tick.
    t = '1;
    t.start_req = 1'b0;
    tick_plan.push_back(t);
    tick_plan.push_back(tick_t'('0));
    plan_read(3'd0, 3'd7, 1'b1);
    plan_read(3'd7, 3'd7, 1'b0);
    plan_read(3'd7, 3'd0, 1'b1);
    plan_read(3'd5, 3'd5, 1'b0);

    // Random: mostly well-formed reads, some bursts of noise that may start
    // reads behind the plan's back, each followed by a settling stretch.
    while (tick_plan.size() < NumTicks) begin
      if ($urandom_range(0, 7) == 0) begin
        for (int unsigned i = $urandom_range(1, 20); i > 0; i--) begin
          tick_plan.push_back(rand_tick($urandom_range(0, 1)));
        end
        for (int unsigned i = 0; i < 68; i++) begin
          tick_plan.push_back(rand_tick(1'b0));
        end
        plan_known = 1'b0;
      end else begin
        this_ch = (plan_known && $urandom_range(0, 2) != 0) ? plan_mux
                                                             : 3'($urandom_range(0, 7));
        next_ch = ($urandom_range(0, 3) == 0) ? this_ch : 3'($urandom_range(0, 7));
        plan_read(this_ch, next_ch, $urandom_range(0, 1));
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Hold until every planned tick is in and every prediction is matched.
    while (ticks_sent < tick_plan.size() || expected_pins.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (5) @(posedge clk_i);

    $display("Checked %0d ticks: %0d completed reads, %0d dummy frames for mux changes,",
             checked, reads_done, dummy_frames);
    $display("%0d starts dropped while busy, receiver hold-off and a full drain included.",
             ignored_starts);
    if (err_cnt == 0 && expected_pins.size() == 0) begin
      $display("[spi_adc_channel_read_sequencer_top] OK");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("[spi_adc_channel_read_sequencer_top] ERROR");
    end
    $finish;
  end

endmodule
